@@ rtl/bti_pkg.sv @@
package bti_pkg;

    // Default table depth and the fixed value width (signed Q16.16).
    localparam int MAX_POINTS_DEF = 16;
    localparam int VAL_W          = 32;

    // Operation codes carried in the input tuser field.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_EVAL   = 2'd2
    } t_op;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_EVL_RD,
        S_EVL_CMP,
        S_EVL_DIV,
        S_EMIT
    } t_state;

    // Request to the multiply-divide unit: quot = floor(mag * num / den).
    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] mag;
        logic [VAL_W-1:0] num;
        logic [VAL_W-1:0] den;
    } t_md_req;

    // Response from the multiply-divide unit.
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
    } t_md_rsp;

endpackage

@@ rtl/bti_table.sv @@
module bti_table #(
    parameter int DEPTH = bti_pkg::MAX_POINTS_DEF,
    parameter int WIDTH = 2 * bti_pkg::VAL_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bti_muldiv.sv @@
module bti_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bti_pkg::t_md_req i_req,
    output bti_pkg::t_md_rsp o_rsp
);

    localparam int W  = bti_pkg::VAL_W;
    localparam int SW = $clog2(W);

    // Accumulator: hi holds the partial product or the partial remainder,
    // lo holds the multiplier bits, then the dividend bits and quotient bits.
    logic          r_busy, n_busy;
    logic          r_div, n_div;
    logic          r_done, n_done;
    logic [SW-1:0] r_step, n_step;
    logic [W-1:0]  r_hi, n_hi;
    logic [W-1:0]  r_lo, n_lo;
    logic [W-1:0]  r_mag, n_mag;
    logic [W-1:0]  r_den, n_den;

    logic [W:0]    w_a, w_b;
    logic [W+1:0]  w_sum;

    // The one shared adder: add in the multiply phase, subtract when dividing.
    always_comb begin
        if (r_div) begin
            w_a   = {r_hi, r_lo[W-1]};
            w_b   = {1'b0, r_den};
            w_sum = {1'b0, w_a} - {1'b0, w_b};
        end else begin
            w_a   = {1'b0, r_hi};
            w_b   = r_lo[0] ? {1'b0, r_mag} : '0;
            w_sum = {1'b0, w_a} + {1'b0, w_b};
        end
    end

    // Step sequencing: W shift-add steps, then W restoring-divide steps.
    always_comb begin
        n_busy = r_busy;
        n_div  = r_div;
        n_done = 1'b0;
        n_step = r_step;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_mag  = r_mag;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_div  = 1'b0;
            n_step = '0;
            n_hi   = '0;
            n_lo   = i_req.num;
            n_mag  = i_req.mag;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_step = r_step + SW'(1);
            if (!r_div) begin
                n_hi = w_sum[W:1];
                n_lo = {w_sum[0], r_lo[W-1:1]};
            end else begin
                n_hi = w_sum[W+1] ? w_a[W-1:0] : w_sum[W-1:0];
                n_lo = {r_lo[W-2:0], ~w_sum[W+1]};
            end
            if (r_step == SW'(W - 1)) begin
                n_step = '0;
                if (r_div) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_div = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_div  <= n_div;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_mag <= n_mag;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_lo;

endmodule

@@ rtl/breakpoint_table_interpolator.sv @@
// Clear, op code 3, a full-table insert and an evaluate on an empty table go straight to the
// result. An insert walks down from the top, moving each point with a larger x up one slot;
// an evaluate scans upward and, between two points, interpolates with the multiply-divide unit
// (32 add and 32 subtract steps). One item at a time: ready returns with the result, which
// waits until the output register is free, so a new item is taken only after the last result.
// Synchronous active-low reset empties the table, not the stored points.
module breakpoint_table_interpolator #(
    parameter int MAX_POINTS = bti_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // x_value[31:0], y_value[63:32]
    input  logic [1:0]  i_s_axis_tuser,  // op[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata   // result_value[31:0], status[32],
                                         // point_count[37:33], zero[39:38]
);

    localparam int W  = bti_pkg::VAL_W;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    bti_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_j, n_j;
    logic [W-1:0]    r_x, n_x;
    logic [W-1:0]    r_y, n_y;
    logic [W-1:0]    r_prev_x, n_prev_x;
    logic [W-1:0]    r_prev_y, n_prev_y;
    logic            r_neg, n_neg;
    logic [W-1:0]    r_res, n_res;
    logic            r_res_status, n_res_status;
    logic            r_ovalid, n_ovalid;
    logic [W-1:0]    r_out_result, n_out_result;
    logic            r_out_status, n_out_status;
    logic [CW-1:0]   r_out_count, n_out_count;

    logic            w_acc;
    bti_pkg::t_op    w_op;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [2*W-1:0]  w_wdata;
    logic [AW-1:0]   w_raddr;
    logic [2*W-1:0]  w_rdata;
    logic [W-1:0]    w_xi, w_yi;
    logic [W:0]      w_dy;
    logic [W-1:0]    w_dy_mag;
    logic [CW-1:0]   w_j_inc;
    logic [CW-1:0]   w_j_dec;
    logic [CW+4:0]   w_cnt_ext;
    bti_pkg::t_md_req w_md_req;
    bti_pkg::t_md_rsp w_md_rsp;

    assign w_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op    = bti_pkg::t_op'(i_s_axis_tuser);
    assign w_xi    = w_rdata[W-1:0];
    assign w_yi    = w_rdata[2*W-1:W];
    assign w_j_inc = r_j + CW'(1);
    assign w_j_dec = r_j - CW'(1);

    // Slope terms for the bracket found in the evaluate scan.
    assign w_dy     = {w_yi[W-1], w_yi} - {r_prev_y[W-1], r_prev_y};
    assign w_dy_mag = w_dy[W] ? W'(-w_dy) : w_dy[W-1:0];

    bti_table #(
        .DEPTH (MAX_POINTS),
        .WIDTH (2 * W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bti_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_rsp   (w_md_rsp)
    );

    // Sequencer: next state, table access and result capture.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_j          = r_j;
        n_x          = r_x;
        n_y          = r_y;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_neg        = r_neg;
        n_res        = r_res;
        n_res_status = r_res_status;
        n_ovalid     = r_ovalid && !i_m_axis_tready;
        n_out_result = r_out_result;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_waddr      = r_j[AW-1:0];
        w_wdata      = w_rdata;
        w_raddr      = r_j[AW-1:0];
        w_md_req     = '0;

        unique case (r_state)
            bti_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_x          = i_s_axis_tdata[W-1:0];
                    n_y          = i_s_axis_tdata[2*W-1:W];
                    n_res        = '0;
                    n_res_status = 1'b0;
                    n_j          = '0;
                    n_state      = bti_pkg::S_EMIT;
                    unique case (w_op)
                        bti_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        bti_pkg::OP_INSERT: begin
                            if (r_count >= CW'(MAX_POINTS)) begin
                                n_res_status = 1'b1;
                            end else begin
                                n_j     = r_count;
                                n_state = (r_count == '0) ? bti_pkg::S_INS_PUT
                                                          : bti_pkg::S_INS_RD;
                            end
                        end
                        bti_pkg::OP_EVAL: begin
                            if (r_count == '0) begin
                                n_res = i_s_axis_tdata[W-1:0];
                            end else begin
                                n_state = bti_pkg::S_EVL_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Insertion walks down from the top, moving larger x up one slot.
            bti_pkg::S_INS_RD: begin
                w_raddr = w_j_dec[AW-1:0];
                n_state = bti_pkg::S_INS_CMP;
            end
            bti_pkg::S_INS_CMP: begin
                if ($signed(w_xi) > $signed(r_x)) begin
                    w_we    = 1'b1;
                    n_j     = w_j_dec;
                    n_state = (w_j_dec == '0) ? bti_pkg::S_INS_PUT : bti_pkg::S_INS_RD;
                end else begin
                    n_state = bti_pkg::S_INS_PUT;
                end
            end
            bti_pkg::S_INS_PUT: begin
                w_we    = 1'b1;
                w_wdata = {r_y, r_x};
                n_count = r_count + CW'(1);
                n_state = bti_pkg::S_EMIT;
            end
            // Evaluation scans upward for the first point with x at or above the query.
            bti_pkg::S_EVL_RD: begin
                n_state = bti_pkg::S_EVL_CMP;
            end
            bti_pkg::S_EVL_CMP: begin
                if ($signed(r_x) <= $signed(w_xi)) begin
                    if (r_j == '0) begin
                        n_res   = w_yi;
                        n_state = bti_pkg::S_EMIT;
                    end else begin
                        w_md_req.start = 1'b1;
                        w_md_req.mag   = w_dy_mag;
                        w_md_req.num   = r_x - r_prev_x;
                        w_md_req.den   = w_xi - r_prev_x;
                        n_neg          = w_dy[W];
                        n_state        = bti_pkg::S_EVL_DIV;
                    end
                end else begin
                    n_prev_x = w_xi;
                    n_prev_y = w_yi;
                    if (w_j_inc == r_count) begin
                        n_res   = w_yi;
                        n_state = bti_pkg::S_EMIT;
                    end else begin
                        n_j     = w_j_inc;
                        n_state = bti_pkg::S_EVL_RD;
                    end
                end
            end
            bti_pkg::S_EVL_DIV: begin
                if (w_md_rsp.done) begin
                    n_res   = r_neg ? r_prev_y - w_md_rsp.quot : r_prev_y + w_md_rsp.quot;
                    n_state = bti_pkg::S_EMIT;
                end
            end
            // Hand the result to the output register once it is free.
            bti_pkg::S_EMIT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid     = 1'b1;
                    n_out_result = r_res;
                    n_out_status = r_res_status;
                    n_out_count  = r_count;
                    n_state      = bti_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bti_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bti_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j          <= n_j;
        r_x          <= n_x;
        r_y          <= n_y;
        r_prev_x     <= n_prev_x;
        r_prev_y     <= n_prev_y;
        r_neg        <= n_neg;
        r_res        <= n_res;
        r_res_status <= n_res_status;
        r_out_result <= n_out_result;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    // Output beat packing; the point count is reported modulo 32.
    assign w_cnt_ext       = {5'b0, r_out_count};
    assign o_s_axis_tready = (r_state == bti_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {2'b00, w_cnt_ext[4:0], r_out_status, r_out_result};

    // The table never holds more points than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count above table depth");

    // An insert into a full table is refused at once.
    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == bti_pkg::OP_INSERT && r_count == CW'(MAX_POINTS))
        |=> (r_state == bti_pkg::S_EMIT && r_res_status && $stable(r_count)))
        else $error("full-table insert not refused");

    // The count moves only when a point is stored or on an accepted beat.
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> ($past(r_state) == bti_pkg::S_INS_PUT || $past(w_acc)))
        else $error("point count changed outside insert or clear");

    // The divider finishes only while the sequencer waits for it.
    a_md_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_rsp.done |-> r_state == bti_pkg::S_EVL_DIV)
        else $error("divider result with no evaluate pending");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = bti_pkg::MAX_POINTS_DEF;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 150;

    // Op code that the block must ignore.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    // One result beat, split into its fields.
    typedef struct packed {
        logic [31:0] value;
        logic        refused;
        logic [4:0]  npoints;
    } t_reply;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata  = '0;  // x_value[31:0], y_value[63:32]
    logic [1:0]  i_s_axis_tuser  = '0;  // op[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // result_value[31:0], status[32],
                                        // point_count[37:33], zero[39:38]

    // Table as the block should hold it after every accepted beat.
    logic signed [31:0] pt_x [TABLE_DEPTH];
    logic signed [31:0] pt_y [TABLE_DEPTH];
    int unsigned        pt_count = 0;

    t_reply expected_replies[$];
    int     n_errors     = 0;
    int     src_idle_pct = 12;
    int     snk_idle_pct = 77;
    logic   hold_go      = 1'b0;
    int     hold_count   = 0;
    int     quiet_cycles = 0;

    breakpoint_table_interpolator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Piecewise linear lookup through the predicted table.
    function automatic logic signed [31:0] lookup_value(input logic signed [31:0] q);
        longint      den;
        longint      num;
        longint      dy;
        logic [127:0] prod;
        logic [127:0] quo;
        if (pt_count == 0) return q;
        if (q <= pt_x[0]) return pt_y[0];
        for (int k = 1; k < pt_count; k++) begin
            if (q <= pt_x[k]) begin
                den = longint'(pt_x[k]) - longint'(pt_x[k-1]);
                if (den == 0) return pt_y[k];
                num  = longint'(q) - longint'(pt_x[k-1]);
                dy   = longint'(pt_y[k]) - longint'(pt_y[k-1]);
                prod = 128'(dy < 0 ? -dy : dy) * 128'(num);
                quo  = prod / 128'(den);
                // The result lies between the two y values, so 32 bits are exact.
                return (dy < 0) ? pt_y[k-1] - quo[31:0] : pt_y[k-1] + quo[31:0];
            end
        end
        return pt_y[pt_count-1];
    endfunction

    // Applies one accepted item to the predicted table and forms its reply.
    function automatic void table_step(input logic [1:0] op, input logic signed [31:0] x_val,
                                       input logic signed [31:0] y_val, output t_reply r);
        int unsigned pos;
        r = '0;
        case (op)
            bti_pkg::OP_CLEAR: begin
                pt_count = 0;
            end
            bti_pkg::OP_INSERT: begin
                if (pt_count >= TABLE_DEPTH) begin
                    r.refused = 1'b1;
                end else begin
                    // Equal x goes after the points already held.
                    pos = 0;
                    while (pos < pt_count && pt_x[pos] <= x_val) pos++;
                    for (int j = pt_count; j > pos; j--) begin
                        pt_x[j] = pt_x[j-1];
                        pt_y[j] = pt_y[j-1];
                    end
                    pt_x[pos] = x_val;
                    pt_y[pos] = y_val;
                    pt_count++;
                end
            end
            bti_pkg::OP_EVAL: begin
                r.value = lookup_value(x_val);
            end
            default: ;
        endcase
        r.npoints = pt_count[4:0];
    endfunction

    // Mix of extremes, full-range values and a narrow band that gives repeated x.
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2, 3:    return $urandom;
            default: return (int'($urandom_range(0, 64)) - 32) * Q_ONE
                            + int'($urandom_range(0, 3)) * 16384;
        endcase
    endfunction

    // Queries land on or right next to held points half the time.
    function automatic logic signed [31:0] rand_query();
        int unsigned k;
        if (pt_count != 0 && $urandom_range(0, 1) == 1) begin
            k = $urandom_range(0, pt_count - 1);
            return pt_x[k] + int'($urandom_range(0, 4)) - 2;
        end
        return rand_coord();
    endfunction

    // Offers one item, waits until it is accepted and records the expected reply.
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] x_val,
                             input logic signed [31:0] y_val);
        t_reply r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {y_val, x_val};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        table_step(op, x_val, y_val, r);
        expected_replies = {expected_replies, r};
    endtask

    // Empty table: evaluate passes x through; the spare op and clear do nothing.
    task automatic test_empty_table();
        send_item(bti_pkg::OP_EVAL, Q_MIN, 32'h0000_0000);
        send_item(bti_pkg::OP_EVAL, Q_MAX, 32'hFFFF_FFFF);
        send_item(OP_SPARE, $urandom, $urandom);
        send_item(bti_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Widest possible bracket, clamping below and above the table.
    task automatic test_extremes();
        send_item(bti_pkg::OP_INSERT, Q_MIN + 1, Q_MAX);
        send_item(bti_pkg::OP_INSERT, Q_MAX - 1, Q_MIN);
        send_item(bti_pkg::OP_EVAL, Q_MIN, 32'h0);
        send_item(bti_pkg::OP_EVAL, Q_MIN + 1, 32'h0);
        send_item(bti_pkg::OP_EVAL, 32'sh0, 32'h0);
        send_item(bti_pkg::OP_EVAL, Q_MAX, 32'h0);
    endtask

    // Fill the table with repeated x, then overflow it and evaluate at a repeat.
    task automatic test_full_table();
        for (int k = 0; k < TABLE_DEPTH - 2; k++)
            send_item(bti_pkg::OP_INSERT, (k % 5 - 2) * Q_ONE, $urandom);
        send_item(bti_pkg::OP_INSERT, $urandom, $urandom);
        send_item(bti_pkg::OP_EVAL, Q_ONE, 32'h0);
        send_item(bti_pkg::OP_EVAL, Q_ONE + Q_ONE / 2, 32'h0);
    endtask

    // Mostly build-then-query sequences, the rest stray items of any op.
    task automatic test_random_tables(input int src_pct, input int snk_pct, input int n_items);
        int sent;
        int npts;
        int nevals;
        src_idle_pct = src_pct;
        snk_idle_pct <= snk_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
                sent++;
            end else begin
                if ($urandom_range(0, 4) != 0) begin
                    send_item(bti_pkg::OP_CLEAR, $urandom, $urandom);
                    sent++;
                end
                npts = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 19)
                                                   : $urandom_range(1, 8);
                for (int k = 0; k < npts; k++)
                    send_item(bti_pkg::OP_INSERT, rand_coord(), $urandom);
                nevals = $urandom_range(2, 8);
                for (int k = 0; k < nevals; k++)
                    send_item(bti_pkg::OP_EVAL, rand_query(), $urandom);
                sent += npts + nevals;
            end
        end
    endtask

    // Receiver holds off long enough that the block stalls its input.
    task automatic test_backpressure();
        src_idle_pct = 0;
        hold_go <= 1'b1;
        send_item(bti_pkg::OP_CLEAR, 32'h0, 32'h0);
        for (int k = 0; k < 3; k++)
            send_item(bti_pkg::OP_INSERT, rand_coord(), $urandom);
        for (int k = 0; k < 4; k++)
            send_item(bti_pkg::OP_EVAL, rand_query(), $urandom);
        i_s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        hold_go <= 1'b0;
    endtask

    // Result-side ready: a long hold-off on request, otherwise random stalls.
    always @(posedge i_clk) begin
        if (hold_go && hold_count < HOLD_CYCLES) begin
            hold_count      <= hold_count + 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (!hold_go) hold_count <= 0;
            i_m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Each result beat is compared with the oldest pending reply.
    always @(posedge i_clk) begin : check_results
        t_reply got;
        t_reply want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[31:0], o_m_axis_tdata[32], o_m_axis_tdata[37:33]};
            if (expected_replies.size() == 0) begin
                $error("result beat with no pending item: tdata=%h", o_m_axis_tdata);
                n_errors++;
            end else begin
                want = expected_replies.pop_front();
                if (got.value !== want.value) begin
                    $error("result_value: expected %h, got %h", want.value, got.value);
                    n_errors++;
                end
                if (got.refused !== want.refused) begin
                    $error("status: expected %0d, got %0d", want.refused, got.refused);
                    n_errors++;
                end
                if (got.npoints !== want.npoints) begin
                    $error("point_count: expected %0d, got %0d", want.npoints, got.npoints);
                    n_errors++;
                end
            end
        end
    end

    // Ends the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_extremes();
        test_full_table();
        test_random_tables(12, 77, 230);
        test_backpressure();
        test_random_tables(77, 12, 230);
        test_random_tables(0, 0, 230);

        i_s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
